// File: rtl/core/scpu_pkg.sv
// Package for the super I/O configuration port: access codes, register
// indexes, masks, reset defaults and the unlock key table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scpu_pkg;

    localparam int DEV_CNT = 4;
    localparam int LDN_W   = $clog2(DEV_CNT);

    // Access codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // Global register indexes
    localparam logic [7:0] IDX_GCTL    = 8'h02;
    localparam logic [7:0] IDX_LDN     = 8'h07;
    localparam logic [7:0] IDX_CHIP_HI = 8'h20;
    localparam logic [7:0] IDX_CHIP_LO = 8'h21;
    localparam logic [7:0] IDX_G22     = 8'h22;
    localparam logic [7:0] IDX_G23     = 8'h23;

    // Logical device register indexes
    localparam logic [7:0] IDX_ACT     = 8'h30;
    localparam logic [7:0] IDX_FDC31   = 8'h31;
    localparam logic [7:0] IDX_BASE_HI = 8'h60;
    localparam logic [7:0] IDX_BASE_LO = 8'h61;
    localparam logic [7:0] IDX_IRQ     = 8'h70;
    localparam logic [7:0] IDX_DMA     = 8'h74;
    localparam logic [7:0] IDX_MODE    = 8'hF0;

    localparam logic [7:0] CHIP_ID_HI  = 8'h86;
    localparam logic [7:0] CHIP_ID_LO  = 8'h61;
    localparam logic [7:0] MASK_G22    = 8'h30;
    localparam logic [7:0] MASK_G23    = 8'h1F;
    localparam logic [7:0] MASK_BASE   = 8'hF8;
    localparam logic [7:0] FDC31_SET   = 8'h55;
    localparam logic [7:0] RD_IDLE     = 8'hFF;

    localparam logic [LDN_W-1:0] LDN_FDC = LDN_W'(0);

    localparam logic [4:0] KEY_LEN = 5'd31;

    localparam logic [7:0] DEF_BASE_HI [DEV_CNT] = '{8'h03, 8'h03, 8'h02, 8'h03};
    localparam logic [7:0] DEF_BASE_LO [DEV_CNT] = '{8'hF0, 8'hF8, 8'hF8, 8'h78};
    localparam logic [3:0] DEF_IRQ     [DEV_CNT] = '{4'd6, 4'd4, 4'd3, 4'd7};
    localparam logic [2:0] DEF_DMA     [DEV_CNT] = '{3'd2, 3'd0, 3'd0, 3'd3};
    localparam logic [3:0] DEF_MODE    [DEV_CNT] = '{4'd0, 4'd0, 4'd0, 4'd3};

    typedef struct packed {
        logic       func;
        logic       port;
        logic [7:0] wdata;
    } t_access;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        is_unlocked;
        logic [2:0]  changed_device;
        logic        dev_enabled;
        logic [15:0] dev_base;
        logic [3:0]  dev_irq;
        logic [2:0]  dev_dma;
        logic [3:0]  dev_mode;
        logic        soft_reset;
    } t_result;

    function automatic logic [7:0] key_byte(input logic [4:0] i);
        logic [7:0] b;
        unique case (i)
            5'd0:  b = 8'h6a;  5'd1:  b = 8'hb5;  5'd2:  b = 8'hda;  5'd3:  b = 8'hed;
            5'd4:  b = 8'hf6;  5'd5:  b = 8'hfb;  5'd6:  b = 8'h7d;  5'd7:  b = 8'hbe;
            5'd8:  b = 8'hdf;  5'd9:  b = 8'h6f;  5'd10: b = 8'h37;  5'd11: b = 8'h1b;
            5'd12: b = 8'h0d;  5'd13: b = 8'h86;  5'd14: b = 8'hc3;  5'd15: b = 8'h61;
            5'd16: b = 8'hb0;  5'd17: b = 8'h58;  5'd18: b = 8'h2c;  5'd19: b = 8'h16;
            5'd20: b = 8'h8b;  5'd21: b = 8'h45;  5'd22: b = 8'ha2;  5'd23: b = 8'hd1;
            5'd24: b = 8'he8;  5'd25: b = 8'h74;  5'd26: b = 8'h3a;  5'd27: b = 8'h9d;
            5'd28: b = 8'hce;  5'd29: b = 8'he7;  5'd30: b = 8'h73;  5'd31: b = 8'h39;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/scpu_if.sv
// Valid/ready channel interfaces for bus access beats and result beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface scpu_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       port;
    logic [7:0] wdata;

    modport source (output valid, func, port, wdata, input ready);
    modport sink   (input valid, func, port, wdata, output ready);
endinterface

interface scpu_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rdata;
    logic        is_unlocked;
    logic [2:0]  changed_device;
    logic        dev_enabled;
    logic [15:0] dev_base;
    logic [3:0]  dev_irq;
    logic [2:0]  dev_dma;
    logic [3:0]  dev_mode;
    logic        soft_reset;

    modport source (output valid, rdata, is_unlocked, changed_device, dev_enabled,
                    dev_base, dev_irq, dev_dma, dev_mode, soft_reset, input ready);
    modport sink   (input valid, rdata, is_unlocked, changed_device, dev_enabled,
                    dev_base, dev_irq, dev_dma, dev_mode, soft_reset, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scpu_key.sv
// Key sequencer: tracks key bytes written to the index port while locked.
// Depends on scpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpu_key (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  scpu_pkg::t_access   i_acc,
    input  wire                 i_lock_req,
    output logic                o_unl,
    output logic                o_unl_next
);
    import scpu_pkg::*;

    logic [4:0] r_cnt;
    logic [4:0] n_cnt;
    logic       r_unl;
    logic       n_unl;
    logic [4:0] cnt_inc;
    logic       key_wr;
    logic       match;

    assign key_wr  = i_fire && !r_unl && i_acc.func == FUNC_WRITE && i_acc.port == PORT_INDEX;
    assign match   = i_acc.wdata == key_byte(r_cnt);
    assign cnt_inc = r_cnt + 5'd1;

    always_comb begin
        n_cnt = r_cnt;
        n_unl = r_unl;
        if (i_fire && i_lock_req) begin
            n_cnt = '0;
            n_unl = 1'b0;
        end else if (key_wr) begin
            // advance on a match, start over on anything else
            n_cnt = match ? cnt_inc : 5'd0;
            n_unl = match && cnt_inc == KEY_LEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_unl <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_unl <= n_unl;
        end
    end

    assign o_unl      = r_unl;
    assign o_unl_next = n_unl;

endmodule

`default_nettype wire

// File: rtl/core/scpu_regs.sv
// Configuration register file: index, global control and logical devices.
// Builds the result beat from the post-access state. Depends on scpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpu_regs (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  scpu_pkg::t_access    i_acc,
    input  wire                  i_unl,
    input  wire                  i_unl_next,
    output logic                 o_lock_req,
    output scpu_pkg::t_result    o_res
);
    import scpu_pkg::*;

    logic [7:0] r_index, n_index;
    logic [7:0] r_g02, n_g02;
    logic [7:0] r_g07, n_g07;
    logic [7:0] r_g22, n_g22;
    logic [7:0] r_g23, n_g23;
    logic [7:0] r_fdc31, n_fdc31;
    logic       r_en   [DEV_CNT];
    logic       n_en   [DEV_CNT];
    logic [7:0] r_bhi  [DEV_CNT];
    logic [7:0] n_bhi  [DEV_CNT];
    logic [7:0] r_blo  [DEV_CNT];
    logic [7:0] n_blo  [DEV_CNT];
    logic [3:0] r_irq  [DEV_CNT];
    logic [3:0] n_irq  [DEV_CNT];
    logic [2:0] r_dma  [DEV_CNT];
    logic [2:0] n_dma  [DEV_CNT];
    logic [3:0] r_mode [DEV_CNT];
    logic [3:0] n_mode [DEV_CNT];

    logic             wr;
    logic             data_wr;
    logic [7:0]       v;
    logic [LDN_W-1:0] ldn;
    logic             ldn_ok;
    logic             dev_take;
    logic             sreset;
    logic [2:0]       changed;
    logic [7:0]       rdata;
    logic [LDN_W-1:0] o_ldn;

    assign v       = i_acc.wdata;
    assign wr      = i_fire && i_acc.func == FUNC_WRITE && i_unl;
    assign data_wr = wr && i_acc.port == PORT_DATA;
    assign ldn     = r_g07[LDN_W-1:0];
    assign ldn_ok  = r_g07[7:LDN_W] == '0;

    always_comb begin
        n_index  = r_index;
        n_g02    = r_g02;
        n_g07    = r_g07;
        n_g22    = r_g22;
        n_g23    = r_g23;
        n_fdc31  = r_fdc31;
        n_en     = r_en;
        n_bhi    = r_bhi;
        n_blo    = r_blo;
        n_irq    = r_irq;
        n_dma    = r_dma;
        n_mode   = r_mode;
        sreset   = 1'b0;
        o_lock_req = 1'b0;
        changed  = 3'd0;
        dev_take = 1'b0;

        if (wr && i_acc.port == PORT_INDEX) begin
            n_index = v;
        end

        if (data_wr) begin
            unique case (r_index)
                IDX_GCTL: begin
                    n_g02      = v;
                    sreset     = v[0];
                    o_lock_req = v[1];
                end
                IDX_LDN: n_g07 = v;
                IDX_G22: n_g22 = v & MASK_G22;
                IDX_G23: n_g23 = v & MASK_G23;
                default: begin
                    // gate on activate, unless this beat turns the device on
                    dev_take = ldn_ok && (r_en[ldn] || (r_index == IDX_ACT && v[0]));
                end
            endcase
        end

        if (dev_take) begin
            changed = {1'b0, ldn} + 3'd1;
            unique case (r_index)
                IDX_ACT:     n_en[ldn] = v[0];
                IDX_FDC31: begin
                    if (ldn == LDN_FDC) begin
                        n_fdc31 = {6'd0, v[1:0]} | (v[0] ? FDC31_SET : 8'h00);
                    end
                end
                IDX_BASE_HI: n_bhi[ldn] = v;
                IDX_BASE_LO: n_blo[ldn] = v & MASK_BASE;
                IDX_IRQ:     n_irq[ldn] = v[3:0];
                IDX_DMA:     n_dma[ldn] = v[2:0];
                IDX_MODE:    n_mode[ldn] = (ldn == LDN_FDC) ? v[3:0] : {2'b00, v[1:0]};
                default: ;
            endcase
        end

        if (sreset) begin
            for (int d = 0; d < DEV_CNT; d++) begin
                n_bhi[d] = DEF_BASE_HI[d];
                n_blo[d] = DEF_BASE_LO[d];
                n_irq[d] = DEF_IRQ[d];
            end
            n_dma[0]  = DEF_DMA[0];
            n_dma[3]  = DEF_DMA[3];
            n_mode[3] = DEF_MODE[3];
        end
    end

    // Data-port read of the global register at the index
    always_comb begin
        rdata = RD_IDLE;
        if (i_acc.func == FUNC_READ && i_acc.port == PORT_DATA) begin
            unique case (r_index)
                IDX_GCTL:    rdata = r_g02;
                IDX_LDN:     rdata = r_g07;
                IDX_CHIP_HI: rdata = CHIP_ID_HI;
                IDX_CHIP_LO: rdata = CHIP_ID_LO;
                IDX_G22:     rdata = r_g22;
                IDX_G23:     rdata = r_g23;
                default:     rdata = 8'h00;
            endcase
        end
    end

    assign o_ldn = n_g07[LDN_W-1:0];

    always_comb begin
        o_res                = '0;
        o_res.rdata          = rdata;
        o_res.is_unlocked    = i_unl_next;
        o_res.changed_device = changed;
        o_res.soft_reset     = sreset;
        if (n_g07[7:LDN_W] == '0) begin
            o_res.dev_enabled = n_en[o_ldn];
            o_res.dev_base    = {n_bhi[o_ldn], n_blo[o_ldn]};
            o_res.dev_irq     = n_irq[o_ldn];
            o_res.dev_dma     = n_dma[o_ldn];
            o_res.dev_mode    = n_mode[o_ldn];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_g02   <= '0;
            r_g07   <= '0;
            r_g22   <= '0;
            r_g23   <= '0;
            r_fdc31 <= '0;
            for (int d = 0; d < DEV_CNT; d++) begin
                r_en[d]   <= 1'b0;
                r_bhi[d]  <= DEF_BASE_HI[d];
                r_blo[d]  <= DEF_BASE_LO[d];
                r_irq[d]  <= DEF_IRQ[d];
                r_dma[d]  <= DEF_DMA[d];
                r_mode[d] <= DEF_MODE[d];
            end
        end else if (i_fire) begin
            r_index <= n_index;
            r_g02   <= n_g02;
            r_g07   <= n_g07;
            r_g22   <= n_g22;
            r_g23   <= n_g23;
            r_fdc31 <= n_fdc31;
            r_en    <= n_en;
            r_bhi   <= n_bhi;
            r_blo   <= n_blo;
            r_irq   <= n_irq;
            r_dma   <= n_dma;
            r_mode  <= n_mode;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/superio_config_port_unlock.sv
// Super I/O configuration port with key unlock. An accepted access beat
// reaches its result beat via the input register and the result register.
// Throughput: one access per cycle unless o_rsp stalls; the key sequencer
// and the register file update as a beat moves between the two registers.
// Reset (i_rst_n, synchronous): port locked, key count and index cleared,
// device resources at their defaults, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module superio_config_port_unlock (
    input  wire        i_clk,
    input  wire        i_rst_n,
    scpu_req_if.sink   i_req,
    scpu_rsp_if.source o_rsp
);
    import scpu_pkg::*;

    logic       r_in_vld;
    t_access    r_in;
    logic       r_out_vld;
    t_result    r_out;
    logic       adv;
    logic       fire;
    logic       in_take;
    logic       lock_req;
    logic       unl;
    logic       unl_next;
    t_result    res;

    // Result register frees up when empty or drained this cycle
    assign adv     = !r_out_vld || o_rsp.ready;
    assign fire    = r_in_vld && adv;
    assign i_req.ready = !r_in_vld || adv;
    assign in_take = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{func: i_req.func, port: i_req.port, wdata: i_req.wdata};
        end
        if (fire) begin
            r_out <= res;
        end
    end

    scpu_key u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_acc      (r_in),
        .i_lock_req (lock_req),
        .o_unl      (unl),
        .o_unl_next (unl_next)
    );

    scpu_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_acc      (r_in),
        .i_unl      (unl),
        .i_unl_next (unl_next),
        .o_lock_req (lock_req),
        .o_res      (res)
    );

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.rdata          = r_out.rdata;
    assign o_rsp.is_unlocked    = r_out.is_unlocked;
    assign o_rsp.changed_device = r_out.changed_device;
    assign o_rsp.dev_enabled    = r_out.dev_enabled;
    assign o_rsp.dev_base       = r_out.dev_base;
    assign o_rsp.dev_irq        = r_out.dev_irq;
    assign o_rsp.dev_dma        = r_out.dev_dma;
    assign o_rsp.dev_mode       = r_out.dev_mode;
    assign o_rsp.soft_reset     = r_out.soft_reset;

    a_dev_write_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.changed_device != 3'd0 |-> unl && unl_next)
        else $error("device write accepted while locked");

    a_sreset_no_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.soft_reset |-> res.changed_device == 3'd0 && unl)
        else $error("soft reset beat also reported a device write");

    a_lock_only_via_gctl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unl && !unl_next |-> fire && lock_req)
        else $error("port locked without a control register write");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_vld && !r_out_vld)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: verif/tb_superio_config_port_unlock.sv
// Testbench for superio_config_port_unlock: drives bus access beats, predicts each
// result beat with a shadow copy of the port state and compares every field.
// Depends on scpu_pkg and the scpu_req_if / scpu_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_superio_config_port_unlock;
    import scpu_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_BEATS = 1250;
    localparam int IDLE_PCT     = 13;
    localparam int MAX_REPORTS  = 10;
    localparam int DEV_LPT      = 3;

    localparam logic [7:0] UNLOCK_KEY [32] = '{
        8'h6a, 8'hb5, 8'hda, 8'hed, 8'hf6, 8'hfb, 8'h7d, 8'hbe,
        8'hdf, 8'h6f, 8'h37, 8'h1b, 8'h0d, 8'h86, 8'hc3, 8'h61,
        8'hb0, 8'h58, 8'h2c, 8'h16, 8'h8b, 8'h45, 8'ha2, 8'hd1,
        8'he8, 8'h74, 8'h3a, 8'h9d, 8'hce, 8'he7, 8'h73, 8'h39
    };

    class config_port_shadow;
        logic [4:0] key_pos;
        logic       unlocked;
        logic [7:0] index;
        logic [7:0] gctl, ldn, g22, g23, chip_hi, chip_lo;
        logic       act     [DEV_CNT];
        logic [7:0] base_hi [DEV_CNT];
        logic [7:0] base_lo [DEV_CNT];
        logic [3:0] irq     [DEV_CNT];
        logic [2:0] dma     [DEV_CNT];
        logic [3:0] mode    [DEV_CNT];
        t_result    expected_beats [$];
        int         mismatch_count;

        function new();
            mismatch_count = 0;
            key_pos  = '0;
            unlocked = 1'b0;
            index    = '0;
            gctl     = '0;
            ldn      = '0;
            g22      = '0;
            g23      = '0;
            for (int d = 0; d < DEV_CNT; d++) begin
                act[d]  = 1'b0;
                dma[d]  = '0;
                mode[d] = '0;
            end
            load_defaults();
        endfunction

        // Soft reset leaves enables, serial dma and the non-parallel modes alone
        function void load_defaults();
            chip_hi = CHIP_ID_HI;
            chip_lo = CHIP_ID_LO;
            for (int d = 0; d < DEV_CNT; d++) begin
                base_hi[d] = DEF_BASE_HI[d];
                base_lo[d] = DEF_BASE_LO[d];
                irq[d]     = DEF_IRQ[d];
            end
            dma[LDN_FDC]  = DEF_DMA[LDN_FDC];
            dma[DEV_LPT]  = DEF_DMA[DEV_LPT];
            mode[DEV_LPT] = DEF_MODE[DEV_LPT];
        endfunction

        function bit device_write(int d, logic [7:0] idx, logic [7:0] v);
            if (!((idx == IDX_ACT && v[0]) || act[d]))
                return 1'b0;
            // Floppy register 31 is not visible at the outputs; the write still counts
            case (idx)
                IDX_ACT:     act[d] = v[0];
                IDX_BASE_HI: base_hi[d] = v;
                IDX_BASE_LO: base_lo[d] = v & MASK_BASE;
                IDX_IRQ:     irq[d] = v[3:0];
                IDX_DMA:     dma[d] = v[2:0];
                IDX_MODE:    mode[d] = (d == LDN_FDC) ? v[3:0] : {2'b00, v[1:0]};
                default: ;
            endcase
            return 1'b1;
        endfunction

        function void note_access(t_access a);
            t_result r;
            int      d;
            r = '0;
            r.rdata = RD_IDLE;
            if (a.func == FUNC_READ) begin
                if (a.port == PORT_DATA) begin
                    case (index)
                        IDX_GCTL:    r.rdata = gctl;
                        IDX_LDN:     r.rdata = ldn;
                        IDX_CHIP_HI: r.rdata = chip_hi;
                        IDX_CHIP_LO: r.rdata = chip_lo;
                        IDX_G22:     r.rdata = g22;
                        IDX_G23:     r.rdata = g23;
                        default:     r.rdata = 8'h00;
                    endcase
                end
            end else if (a.port == PORT_INDEX) begin
                if (!unlocked) begin
                    // A mismatch drops back to the start, it is not rechecked
                    if (a.wdata == UNLOCK_KEY[key_pos])
                        key_pos = key_pos + 5'd1;
                    else
                        key_pos = '0;
                    if (key_pos == KEY_LEN)
                        unlocked = 1'b1;
                end else begin
                    index = a.wdata;
                end
            end else if (unlocked) begin
                case (index)
                    IDX_GCTL: begin
                        gctl = a.wdata;
                        if (a.wdata[0]) begin
                            load_defaults();
                            r.soft_reset = 1'b1;
                        end
                        if (a.wdata[1]) begin
                            unlocked = 1'b0;
                            key_pos  = '0;
                        end
                    end
                    IDX_LDN: ldn = a.wdata;
                    IDX_G22: g22 = a.wdata & MASK_G22;
                    IDX_G23: g23 = a.wdata & MASK_G23;
                    default: begin
                        if (ldn < DEV_CNT && device_write(int'(ldn), index, a.wdata))
                            r.changed_device = ldn[2:0] + 3'd1;
                    end
                endcase
            end
            r.is_unlocked = unlocked;
            if (ldn < DEV_CNT) begin
                d = int'(ldn);
                r.dev_enabled = act[d];
                r.dev_base    = {base_hi[d], base_lo[d]};
                r.dev_irq     = irq[d];
                r.dev_dma     = dma[d];
                r.dev_mode    = mode[d];
            end
            expected_beats.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_beats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: result beat with nothing expected: %h", got);
                return;
            end
            want = expected_beats.pop_front();
            if (got.rdata !== want.rdata || got.is_unlocked !== want.is_unlocked ||
                got.changed_device !== want.changed_device ||
                got.dev_enabled !== want.dev_enabled || got.dev_base !== want.dev_base ||
                got.dev_irq !== want.dev_irq || got.dev_dma !== want.dev_dma ||
                got.dev_mode !== want.dev_mode || got.soft_reset !== want.soft_reset) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: exp rdata %h unl %b chg %0d en %b base %h irq %0d dma %0d mode %0d srst %b",
                             want.rdata, want.is_unlocked, want.changed_device, want.dev_enabled,
                             want.dev_base, want.dev_irq, want.dev_dma, want.dev_mode,
                             want.soft_reset);
                    $display("       got rdata %h unl %b chg %0d en %b base %h irq %0d dma %0d mode %0d srst %b",
                             got.rdata, got.is_unlocked, got.changed_device, got.dev_enabled,
                             got.dev_base, got.dev_irq, got.dev_dma, got.dev_mode,
                             got.soft_reset);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady = 1'b0;
    int   beats_sent = 0;
    int   stall_cycles = 0;

    config_port_shadow shadow = new();

    scpu_req_if req ();
    scpu_rsp_if rsp ();

    superio_config_port_unlock dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #1 i_clk = ~i_clk;

    // Sample both channels on the pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req.valid && req.ready)
                shadow.note_access(t_access'{req.func, req.port, req.wdata});
            if (rsp.valid && rsp.ready)
                shadow.check_result(t_result'{rsp.rdata, rsp.is_unlocked, rsp.changed_device,
                                              rsp.dev_enabled, rsp.dev_base, rsp.dev_irq,
                                              rsp.dev_dma, rsp.dev_mode, rsp.soft_reset});
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("superio_config_port_unlock verification failed");
        $finish;
    end

    task automatic send_access(logic fn, logic pt, logic [7:0] v);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.func  <= fn;
        req.port  <= pt;
        req.wdata <= v;
        do @(posedge i_clk); while (!req.ready);
        beats_sent++;
    endtask

    task automatic write_index(logic [7:0] v);
        send_access(FUNC_WRITE, PORT_INDEX, v);
    endtask

    task automatic write_data(logic [7:0] v);
        send_access(FUNC_WRITE, PORT_DATA, v);
    endtask

    task automatic reg_write(logic [7:0] idx, logic [7:0] v);
        write_index(idx);
        write_data(v);
    endtask

    task automatic reg_read(logic [7:0] idx);
        write_index(idx);
        send_access(FUNC_READ, PORT_DATA, 8'($urandom));
    endtask

    // Lead with a byte that is never in the key so the match count starts at zero
    task automatic unlock_port();
        write_index(8'h00);
        for (int k = 0; k < 31; k++)
            write_index(UNLOCK_KEY[k]);
    endtask

    task automatic broken_key(int len);
        write_index(8'h00);
        for (int k = 0; k < len; k++)
            write_index(UNLOCK_KEY[k]);
        write_index(8'($urandom));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_index();
        case ($urandom_range(12))
            0:       return IDX_LDN;
            1:       return IDX_CHIP_HI;
            2:       return IDX_CHIP_LO;
            3:       return IDX_G22;
            4:       return IDX_G23;
            5:       return IDX_ACT;
            6:       return IDX_FDC31;
            7:       return IDX_BASE_HI;
            8:       return IDX_BASE_LO;
            9:       return IDX_IRQ;
            10:      return IDX_DMA;
            11:      return IDX_MODE;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int         random_start;
        int         pick;
        logic       pressured;
        logic [7:0] idx;
        logic [7:0] v;

        i_rst_n   <= 1'b0;
        req.valid <= 1'b0;
        req.func  <= FUNC_WRITE;
        req.port  <= PORT_INDEX;
        req.wdata <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Locked: reads work, data writes are dropped, a broken key does not unlock
        send_access(FUNC_READ, PORT_INDEX, 8'hFF);
        send_access(FUNC_READ, PORT_DATA, 8'h00);
        write_data(8'hA5);
        broken_key(2);
        unlock_port();
        send_access(FUNC_READ, PORT_INDEX, 8'h5A);

        // Floppy: writes held off until activated, then masked
        reg_write(IDX_LDN, 8'h00);
        reg_write(IDX_BASE_HI, 8'hFF);
        reg_write(IDX_ACT, 8'hFE);
        reg_write(IDX_ACT, 8'h01);
        reg_write(IDX_BASE_LO, 8'hFF);
        reg_write(IDX_IRQ, 8'hFF);
        reg_write(IDX_MODE, 8'hFF);
        reg_write(IDX_CHIP_HI, 8'h00);
        reg_read(IDX_CHIP_LO);
        reg_write(IDX_G22, 8'hFF);
        reg_read(IDX_G23);

        // Unknown device reports zeros and ignores device writes; then the parallel port is enabled
        reg_write(IDX_LDN, 8'hFF);
        reg_write(IDX_ACT, 8'h01);
        reg_write(IDX_LDN, 8'h03);
        reg_write(IDX_ACT, 8'h01);
        reg_write(IDX_MODE, 8'hFF);

        // Soft reset together with lock, then a read while locked
        reg_write(IDX_GCTL, 8'h03);
        send_access(FUNC_READ, PORT_DATA, 8'h00);

        random_start = beats_sent;
        pressured    = 1'b0;
        while (beats_sent < random_start + RANDOM_BEATS) begin
            steady = (beats_sent - random_start >= 300) && (beats_sent - random_start < 550);
            if (!pressured && beats_sent - random_start >= RANDOM_BEATS / 2) begin
                drain();
                pressured = 1'b1;
            end
            pick = $urandom_range(99);
            if (!shadow.unlocked) begin
                if (pick < 70)
                    unlock_port();
                else if (pick < 85)
                    broken_key($urandom_range(29, 1));
                else
                    send_access(1'($urandom), 1'($urandom), 8'($urandom));
            end else begin
                if (pick < 3) begin
                    reg_write(IDX_GCTL, 8'($urandom));
                end else if (pick < 15) begin
                    if ($urandom_range(9) == 0)
                        v = 8'($urandom);
                    else
                        v = 8'($urandom_range(3));
                    reg_write(IDX_LDN, v);
                end else if (pick < 22) begin
                    send_access(1'($urandom), 1'($urandom), 8'($urandom));
                end else if (pick < 32) begin
                    reg_read(pick_index());
                end else if (pick < 36) begin
                    send_access(FUNC_READ, PORT_INDEX, 8'($urandom));
                end else begin
                    idx = pick_index();
                    v   = 8'($urandom);
                    if (idx == IDX_ACT)
                        v[0] = ($urandom_range(3) != 0);
                    reg_write(idx, v);
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (shadow.mismatch_count == 0 && shadow.expected_beats.size() == 0)
            $display("superio_config_port_unlock verification clean");
        else
            $display("superio_config_port_unlock verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/scpu_pkg.sv
rtl/core/scpu_if.sv
rtl/core/scpu_key.sv
rtl/core/scpu_regs.sv
rtl/core/superio_config_port_unlock.sv
verif/tb_superio_config_port_unlock.sv
